/* sv/first_fit_segment_allocator_defines.svh */
// ============================================================================
// first_fit_segment_allocator_defines.svh
// Assertion macros used by the allocator controller.
// ============================================================================
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define FFSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ffsa_pkg.sv */
// ============================================================================
// ffsa_pkg
// Types and constants of the first-fit segment allocator.
// ============================================================================
package ffsa_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int MAX_SEGMENTS = 64;
    localparam int OFS_W        = $clog2(HEAP_BYTES);
    localparam int LEN_W        = OFS_W + 1;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_ZALLOC = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADFREE = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_PREP, S_CHECK, S_SCAN, S_FOUND, S_UP, S_SPLIT,
        S_MARK, S_NB0, S_NB1, S_NB2, S_MERGE, S_DN, S_OUT
    } t_state;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             free;
    } t_seg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_seg             wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic             ok;
        logic             fail;
        logic             rel;
        logic [LEN_W-1:0] size;
        logic [OFS_W-1:0] start;
        logic [63:0]      fail_bytes;
    } t_stat_upd;

    typedef struct packed {
        logic [31:0]      active_count;
        logic [31:0]      total_count;
        logic [31:0]      fail_count;
        logic [LEN_W-1:0] active_bytes;
        logic [31:0]      total_bytes;
        logic [63:0]      fail_bytes;
        logic [OFS_W-1:0] highest_byte;
    } t_stats;

endpackage

/* sv/ffsa_if.sv */
// ============================================================================
// ffsa_in_if / ffsa_out_if
// Request and response channels, valid/ready handshake.
// ============================================================================
interface ffsa_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [31:0]                req_size;
    logic [31:0]                elem_count;
    logic [ffsa_pkg::OFS_W-1:0] free_offset;
    logic                       null_pointer;

    modport source (output valid, cmd, req_size, elem_count, free_offset, null_pointer,
                    input ready);
    modport sink   (input valid, cmd, req_size, elem_count, free_offset, null_pointer,
                    output ready);
endinterface

interface ffsa_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [ffsa_pkg::OFS_W-1:0] alloc_offset;
    logic [31:0]                active_count;
    logic [31:0]                total_count;
    logic [31:0]                fail_count;
    logic [ffsa_pkg::LEN_W-1:0] active_bytes;
    logic [31:0]                total_bytes;
    logic [63:0]                fail_bytes;
    logic [ffsa_pkg::OFS_W-1:0] highest_byte;

    modport source (output valid, status, alloc_offset, active_count, total_count,
                    fail_count, active_bytes, total_bytes, fail_bytes, highest_byte,
                    input ready);
    modport sink   (input valid, status, alloc_offset, active_count, total_count,
                    fail_count, active_bytes, total_bytes, fail_bytes, highest_byte,
                    output ready);
endinterface

/* sv/ffsa_seg_ram.sv */
// ============================================================================
// ffsa_seg_ram
// Segment table: one write port, one read port, registered read data.
// ============================================================================
module ffsa_seg_ram (
    input  logic                 i_clk,
    input  ffsa_pkg::t_mem_req   i_req,
    output ffsa_pkg::t_seg       o_rdata
);

    ffsa_pkg::t_seg r_mem [ffsa_pkg::MAX_SEGMENTS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

/* sv/ffsa_stats.sv */
// ============================================================================
// ffsa_stats
// Allocation statistics counters.
// ============================================================================
module ffsa_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffsa_pkg::t_stat_upd i_upd,
    output ffsa_pkg::t_stats    o_stats
);

    ffsa_pkg::t_stats r_st, n_st;
    logic [ffsa_pkg::LEN_W-1:0] w_last;

    always_comb begin
        n_st   = r_st;
        w_last = {1'b0, i_upd.start} + i_upd.size - 1'b1;
        if (i_upd.ok) begin
            n_st.active_count = r_st.active_count + 32'd1;
            n_st.total_count  = r_st.total_count + 32'd1;
            n_st.active_bytes = r_st.active_bytes + i_upd.size;
            n_st.total_bytes  = r_st.total_bytes + 32'(i_upd.size);
            if (w_last[ffsa_pkg::OFS_W-1:0] > r_st.highest_byte) begin
                n_st.highest_byte = w_last[ffsa_pkg::OFS_W-1:0];
            end
        end
        if (i_upd.fail) begin
            n_st.fail_count = r_st.fail_count + 32'd1;
            n_st.fail_bytes = r_st.fail_bytes + i_upd.fail_bytes;
        end
        if (i_upd.rel) begin
            n_st.active_count = r_st.active_count - 32'd1;
            n_st.active_bytes = r_st.active_bytes - i_upd.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_stats = r_st;

endmodule

/* sv/ffsa_ctrl.sv */
// ============================================================================
// ffsa_ctrl
// Sequencer: scans the segment table, splits, merges and shifts entries.
// ============================================================================
`include "first_fit_segment_allocator_defines.svh"

module ffsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ffsa_in_if.sink             i_req,
    ffsa_out_if.source          o_rsp,
    output ffsa_pkg::t_mem_req  o_mem,
    input  ffsa_pkg::t_seg      i_rdata,
    output ffsa_pkg::t_stat_upd o_upd,
    input  ffsa_pkg::t_stats    i_stats
);

    localparam int IW = ffsa_pkg::IDX_W;
    localparam int CW = ffsa_pkg::CNT_W;
    localparam int LW = ffsa_pkg::LEN_W;
    localparam int OW = ffsa_pkg::OFS_W;

    ffsa_pkg::t_state  r_state, n_state;
    ffsa_pkg::t_cmd    r_cmd, n_cmd;
    logic [31:0]       r_size, n_size;
    logic [31:0]       r_count, n_count;
    logic [OW-1:0]     r_offset, n_offset;
    logic              r_null, n_null;
    logic [63:0]       r_bytes, n_bytes;
    logic [CW-1:0]     r_used, n_used;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_hit, n_hit;
    logic [IW-1:0]     r_j, n_j;
    logic [1:0]        r_k, n_k;
    ffsa_pkg::t_seg    r_ent, n_ent;
    ffsa_pkg::t_seg    r_next, n_next;
    ffsa_pkg::t_seg    r_prev, n_prev;
    ffsa_pkg::t_status r_status, n_status;
    logic [OW-1:0]     r_goff, n_goff;
    logic              r_ovld, n_ovld;
    ffsa_pkg::t_status r_o_status, n_o_status;
    logic [OW-1:0]     r_o_off, n_o_off;
    ffsa_pkg::t_stats  r_o_st, n_o_st;

    logic [LW-1:0]     w_size;
    logic [63:0]       w_eff;
    logic              w_hit, w_last, w_nf, w_pf, w_load;
    logic [CW-1:0]     w_src;
    logic [IW-1:0]     w_m;
    ffsa_pkg::t_seg    w_merged;
    logic              w_fin;
    ffsa_pkg::t_status w_fin_st;
    logic [OW-1:0]     w_fin_off;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_size     = r_size;
        n_count    = r_count;
        n_offset   = r_offset;
        n_null     = r_null;
        n_bytes    = r_bytes;
        n_used     = r_used;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_j        = r_j;
        n_k        = r_k;
        n_ent      = r_ent;
        n_next     = r_next;
        n_prev     = r_prev;
        n_status   = r_status;
        n_goff     = r_goff;
        n_o_status = r_o_status;
        n_o_off    = r_o_off;
        n_o_st     = r_o_st;
        n_ovld     = r_ovld && !o_rsp.ready;
        o_mem      = '0;
        o_upd      = '0;
        i_req.ready = 1'b0;
        w_fin      = 1'b0;
        w_fin_st   = ffsa_pkg::ST_OK;
        w_fin_off  = '0;
        w_load     = 1'b0;

        w_size = r_bytes[LW-1:0];
        w_eff  = (r_bytes == 64'd0) ? 64'd1 : r_bytes;
        w_hit  = (r_cmd == ffsa_pkg::CMD_FREE)
               ? (!i_rdata.free && i_rdata.start == r_offset)
               : (i_rdata.free && i_rdata.len >= w_size);
        w_last = ({1'b0, r_idx} + 1'b1) == r_used;
        w_nf   = (({1'b0, r_hit} + 1'b1) < r_used) && r_next.free;
        w_pf   = (r_hit != '0) && r_prev.free;
        w_m    = w_pf ? (r_hit - 1'b1) : r_hit;
        w_merged.free  = 1'b1;
        w_merged.start = w_pf ? r_prev.start : r_ent.start;
        w_merged.len   = r_ent.len + (w_pf ? r_prev.len : '0) + (w_nf ? r_next.len : '0);
        w_src  = {1'b0, r_hit} + 1'b1 + CW'(w_nf);

        unique case (r_state)
            ffsa_pkg::S_INIT: begin
                o_mem.we          = 1'b1;
                o_mem.wdata.start = '0;
                o_mem.wdata.len   = LW'(ffsa_pkg::HEAP_BYTES);
                o_mem.wdata.free  = 1'b1;
                n_used            = CW'(1);
                n_state           = ffsa_pkg::S_IDLE;
            end
            ffsa_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_cmd    = ffsa_pkg::t_cmd'(i_req.cmd);
                    n_size   = i_req.req_size;
                    n_count  = i_req.elem_count;
                    n_offset = i_req.free_offset;
                    n_null   = i_req.null_pointer;
                    n_state  = ffsa_pkg::S_PREP;
                end
            end
            ffsa_pkg::S_PREP: begin
                unique case (r_cmd)
                    ffsa_pkg::CMD_ALLOC: begin
                        n_bytes = {32'd0, r_size};
                        n_state = ffsa_pkg::S_CHECK;
                    end
                    ffsa_pkg::CMD_ZALLOC: begin
                        n_bytes = r_size * r_count;
                        n_state = ffsa_pkg::S_CHECK;
                    end
                    ffsa_pkg::CMD_FREE: begin
                        if (r_null) begin
                            w_fin = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_state = ffsa_pkg::S_SCAN;
                        end
                    end
                    default: begin
                        w_fin = 1'b1;
                    end
                endcase
            end
            ffsa_pkg::S_CHECK: begin
                if (w_eff > 64'(ffsa_pkg::HEAP_BYTES)) begin
                    o_upd.fail       = 1'b1;
                    o_upd.fail_bytes = w_eff;
                    w_fin            = 1'b1;
                    w_fin_st         = ffsa_pkg::ST_NOFIT;
                end else begin
                    n_bytes = w_eff;
                    n_idx   = '0;
                    n_state = ffsa_pkg::S_SCAN;
                end
            end
            ffsa_pkg::S_SCAN: begin
                o_mem.raddr = r_idx + 1'b1;
                if (w_hit) begin
                    n_hit   = r_idx;
                    n_ent   = i_rdata;
                    n_state = (r_cmd == ffsa_pkg::CMD_FREE) ? ffsa_pkg::S_NB0
                                                            : ffsa_pkg::S_FOUND;
                end else if (w_last) begin
                    w_fin = 1'b1;
                    if (r_cmd == ffsa_pkg::CMD_FREE) begin
                        w_fin_st = ffsa_pkg::ST_BADFREE;
                    end else begin
                        w_fin_st         = ffsa_pkg::ST_NOFIT;
                        o_upd.fail       = 1'b1;
                        o_upd.fail_bytes = r_bytes;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ffsa_pkg::S_FOUND: begin
                if (r_ent.len > w_size) begin
                    if (r_used == CW'(ffsa_pkg::MAX_SEGMENTS)) begin
                        o_upd.fail       = 1'b1;
                        o_upd.fail_bytes = r_bytes;
                        w_fin            = 1'b1;
                        w_fin_st         = ffsa_pkg::ST_FULL;
                    end else if (({1'b0, r_hit} + 1'b1) < r_used) begin
                        o_mem.raddr = IW'(r_used - 1'b1);
                        n_j         = IW'(r_used - 1'b1);
                        n_state     = ffsa_pkg::S_UP;
                    end else begin
                        n_state = ffsa_pkg::S_SPLIT;
                    end
                end else begin
                    n_state = ffsa_pkg::S_MARK;
                end
            end
            ffsa_pkg::S_UP: begin
                // move entry j up by one, tail first
                o_mem.we    = 1'b1;
                o_mem.waddr = r_j + 1'b1;
                o_mem.wdata = i_rdata;
                if (r_j == r_hit + 1'b1) begin
                    n_state = ffsa_pkg::S_SPLIT;
                end else begin
                    o_mem.raddr = r_j - 1'b1;
                    n_j         = r_j - 1'b1;
                end
            end
            ffsa_pkg::S_SPLIT: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_hit + 1'b1;
                o_mem.wdata.start = r_ent.start + w_size[OW-1:0];
                o_mem.wdata.len   = r_ent.len - w_size;
                o_mem.wdata.free  = 1'b1;
                n_used            = r_used + 1'b1;
                n_state           = ffsa_pkg::S_MARK;
            end
            ffsa_pkg::S_MARK: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_hit;
                o_mem.wdata.start = r_ent.start;
                o_mem.wdata.len   = w_size;
                o_mem.wdata.free  = 1'b0;
                o_upd.ok          = 1'b1;
                o_upd.size        = w_size;
                o_upd.start       = r_ent.start;
                w_fin             = 1'b1;
                w_fin_off         = r_ent.start;
            end
            ffsa_pkg::S_NB0: begin
                o_mem.raddr = r_hit + 1'b1;
                n_state     = ffsa_pkg::S_NB1;
            end
            ffsa_pkg::S_NB1: begin
                n_next      = i_rdata;
                o_mem.raddr = r_hit - 1'b1;
                n_state     = ffsa_pkg::S_NB2;
            end
            ffsa_pkg::S_NB2: begin
                n_prev  = i_rdata;
                n_state = ffsa_pkg::S_MERGE;
            end
            ffsa_pkg::S_MERGE: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = w_m;
                o_mem.wdata = w_merged;
                n_k         = 2'(w_nf) + 2'(w_pf);
                o_upd.rel   = 1'b1;
                o_upd.size  = r_ent.len;
                if ((w_nf || w_pf) && w_src < r_used) begin
                    o_mem.raddr = w_src[IW-1:0];
                    n_j         = w_src[IW-1:0];
                    n_state     = ffsa_pkg::S_DN;
                end else begin
                    n_used = r_used - CW'(w_nf) - CW'(w_pf);
                    w_fin  = 1'b1;
                end
            end
            ffsa_pkg::S_DN: begin
                // close the gap left by merged entries
                o_mem.we    = 1'b1;
                o_mem.waddr = r_j - IW'(r_k);
                o_mem.wdata = i_rdata;
                if (({1'b0, r_j} + 1'b1) == r_used) begin
                    n_used = r_used - CW'(r_k);
                    w_fin  = 1'b1;
                end else begin
                    o_mem.raddr = r_j + 1'b1;
                    n_j         = r_j + 1'b1;
                end
            end
            ffsa_pkg::S_OUT: begin
                if (!r_ovld || o_rsp.ready) begin
                    w_load     = 1'b1;
                    n_ovld     = 1'b1;
                    n_o_status = r_status;
                    n_o_off    = r_goff;
                    n_o_st     = i_stats;
                    n_state    = ffsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffsa_pkg::S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_status = w_fin_st;
            n_goff   = w_fin_off;
            n_state  = ffsa_pkg::S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffsa_pkg::S_INIT;
            r_used  <= CW'(1);
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_size     <= n_size;
        r_count    <= n_count;
        r_offset   <= n_offset;
        r_null     <= n_null;
        r_bytes    <= n_bytes;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_j        <= n_j;
        r_k        <= n_k;
        r_ent      <= n_ent;
        r_next     <= n_next;
        r_prev     <= n_prev;
        r_status   <= n_status;
        r_goff     <= n_goff;
        r_o_status <= n_o_status;
        r_o_off    <= n_o_off;
        r_o_st     <= n_o_st;
    end

    assign o_rsp.valid        = r_ovld;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.alloc_offset = r_o_off;
    assign o_rsp.active_count = r_o_st.active_count;
    assign o_rsp.total_count  = r_o_st.total_count;
    assign o_rsp.fail_count   = r_o_st.fail_count;
    assign o_rsp.active_bytes = r_o_st.active_bytes;
    assign o_rsp.total_bytes  = r_o_st.total_bytes;
    assign o_rsp.fail_bytes   = r_o_st.fail_bytes;
    assign o_rsp.highest_byte = r_o_st.highest_byte;

    `FFSA_ASSERT_NOW(a_used_range, 1'b1,
        (r_used != '0 && r_used <= CW'(ffsa_pkg::MAX_SEGMENTS)), "segment count out of range")
    `FFSA_ASSERT_NOW(a_upd_onehot, 1'b1, $onehot0({o_upd.ok, o_upd.fail, o_upd.rel}),
        "conflicting statistics updates")
    `FFSA_ASSERT_NOW(a_scan_no_write, (r_state == ffsa_pkg::S_SCAN), !o_mem.we,
        "table written during scan")
    `FFSA_ASSERT_NEXT(a_load_idle, w_load, (r_state == ffsa_pkg::S_IDLE && o_rsp.valid),
        "result load did not return to idle")

endmodule

/* sv/first_fit_segment_allocator.sv */
// ============================================================================
// first_fit_segment_allocator
// First-fit heap allocator with coalescing over a segment table in RAM.
// ============================================================================
// channel  | dir | modport            | transaction
// i_req    | in  | ffsa_in_if.sink    | allocate / free / zeroed allocate request
// o_rsp    | out | ffsa_out_if.source | status, offset and statistics
//
// Scan and table shift each walk the segment RAM one entry per cycle
// through its single read port.
// Reset: 1 cycle after reset release to write the initial segment.
// A finished result waits in the output register; a new request is taken
// while it waits, and the next result holds until it is taken.
module first_fit_segment_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffsa_in_if.sink     i_req,
    ffsa_out_if.source  o_rsp
);

    ffsa_pkg::t_mem_req  w_mem;
    ffsa_pkg::t_seg      w_rdata;
    ffsa_pkg::t_stat_upd w_upd;
    ffsa_pkg::t_stats    w_stats;

    ffsa_seg_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    ffsa_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_upd),
        .o_stats (w_stats)
    );

    ffsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (w_mem),
        .i_rdata (w_rdata),
        .o_upd   (w_upd),
        .i_stats (w_stats)
    );

endmodule

/* tb/sv/first_fit_segment_allocator_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// first_fit_segment_allocator_tb
// Drives allocate, free and zeroed-allocate requests into the allocator and
// checks every response, including the statistics counters, against a
// behavioral model of the segment table kept in the testbench.
// ============================================================================

class heap_scoreboard;
    // model of the segment table
    int unsigned seg_start [ffsa_pkg::MAX_SEGMENTS];
    int unsigned seg_len   [ffsa_pkg::MAX_SEGMENTS];
    bit          seg_free  [ffsa_pkg::MAX_SEGMENTS];
    int unsigned seg_cnt;
    bit [31:0] act_cnt, tot_cnt, fail_cnt, tot_bytes;
    bit [16:0] act_bytes;
    bit [63:0] fail_bytes;
    bit [15:0] high_byte;
    // expected responses: status, offset, then stats
    bit [1:0]  exp_status[$];
    bit [15:0] exp_offset[$];
    ffsa_pkg::t_stats exp_stats[$];
    int errors;
    int allocs_ok, frees_ok, fulls, nofits, badfrees;

    function new();
        seg_cnt = 1;
        seg_start[0] = 0;
        seg_len[0] = ffsa_pkg::HEAP_BYTES;
        seg_free[0] = 1;
        act_cnt = 0; tot_cnt = 0; fail_cnt = 0; tot_bytes = 0;
        act_bytes = 0; fail_bytes = 0; high_byte = 0;
        errors = 0;
    endfunction

    function void remove_seg(int unsigned k);
        for (int unsigned j = k; j + 1 < seg_cnt; j++) begin
            seg_start[j] = seg_start[j+1];
            seg_len[j]   = seg_len[j+1];
            seg_free[j]  = seg_free[j+1];
        end
        seg_cnt--;
    endfunction

    function ffsa_pkg::t_status alloc_bytes(bit [63:0] bytes, output bit [15:0] ofs);
        int unsigned hit;
        int unsigned sz;
        hit = seg_cnt;
        ofs = 0;
        if (bytes == 0) bytes = 1;
        if (bytes > ffsa_pkg::HEAP_BYTES) begin
            fail_cnt++; fail_bytes += bytes;
            return ffsa_pkg::ST_NOFIT;
        end
        sz = 32'(bytes);
        for (int unsigned i = 0; i < seg_cnt; i++)
            if (seg_free[i] && seg_len[i] >= sz) begin
                hit = i;
                break;
            end
        if (hit >= seg_cnt) begin
            fail_cnt++; fail_bytes += bytes;
            return ffsa_pkg::ST_NOFIT;
        end
        if (seg_len[hit] > sz) begin
            if (seg_cnt >= ffsa_pkg::MAX_SEGMENTS) begin
                fail_cnt++; fail_bytes += bytes;
                return ffsa_pkg::ST_FULL;
            end
            for (int unsigned i = seg_cnt; i > hit + 1; i--) begin
                seg_start[i] = seg_start[i-1];
                seg_len[i]   = seg_len[i-1];
                seg_free[i]  = seg_free[i-1];
            end
            seg_start[hit+1] = seg_start[hit] + sz;
            seg_len[hit+1]   = seg_len[hit] - sz;
            seg_free[hit+1]  = 1;
            seg_cnt++;
            seg_len[hit] = sz;
        end
        seg_free[hit] = 0;
        ofs = 16'(seg_start[hit]);
        act_cnt++; tot_cnt++;
        act_bytes += 17'(sz); tot_bytes += sz;
        if (seg_start[hit] + sz - 1 > high_byte) high_byte = 16'(seg_start[hit] + sz - 1);
        return ffsa_pkg::ST_OK;
    endfunction

    function ffsa_pkg::t_status release_block(int unsigned ofs);
        int unsigned hit;
        hit = seg_cnt;
        for (int unsigned i = 0; i < seg_cnt; i++)
            if (!seg_free[i] && seg_start[i] == ofs) begin
                hit = i;
                break;
            end
        if (hit >= seg_cnt) return ffsa_pkg::ST_BADFREE;
        act_bytes -= 17'(seg_len[hit]);
        act_cnt--;
        seg_free[hit] = 1;
        if (hit + 1 < seg_cnt && seg_free[hit+1]) begin
            seg_len[hit] += seg_len[hit+1];
            remove_seg(hit + 1);
        end
        if (hit > 0 && seg_free[hit-1]) begin
            seg_len[hit-1] += seg_len[hit];
            remove_seg(hit);
        end
        return ffsa_pkg::ST_OK;
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(ffsa_pkg::t_cmd cmd, bit [31:0] sz, bit [31:0] cnt,
                               bit [15:0] ofs, bit is_null);
        ffsa_pkg::t_status st;
        bit [15:0] got;
        bit [63:0] prod;
        ffsa_pkg::t_stats s;
        st = ffsa_pkg::ST_OK;
        got = 0;
        case (cmd)
            ffsa_pkg::CMD_ALLOC: st = alloc_bytes({32'd0, sz}, got);
            ffsa_pkg::CMD_FREE: if (!is_null) st = release_block({16'd0, ofs});
            ffsa_pkg::CMD_ZALLOC: begin
                prod = {32'd0, sz} * {32'd0, cnt};
                if (prod > ffsa_pkg::HEAP_BYTES) begin
                    fail_cnt++; fail_bytes += prod;
                    st = ffsa_pkg::ST_NOFIT;
                end else begin
                    st = alloc_bytes(prod, got);
                end
            end
            default: ;
        endcase
        if (st != ffsa_pkg::ST_OK) got = 0;
        case (st)
            ffsa_pkg::ST_OK:      if (cmd == ffsa_pkg::CMD_FREE && !is_null) frees_ok++;
                                  else if (cmd == ffsa_pkg::CMD_ALLOC ||
                                           cmd == ffsa_pkg::CMD_ZALLOC) allocs_ok++;
            ffsa_pkg::ST_NOFIT:   nofits++;
            ffsa_pkg::ST_BADFREE: badfrees++;
            default:              fulls++;
        endcase
        s.active_count = act_cnt;  s.total_count = tot_cnt;  s.fail_count = fail_cnt;
        s.active_bytes = act_bytes; s.total_bytes = tot_bytes; s.fail_bytes = fail_bytes;
        s.highest_byte = high_byte;
        exp_status.push_back(st);
        exp_offset.push_back(got);
        exp_stats.push_back(s);
    endfunction

    function void check_response(bit [1:0] st, bit [15:0] ofs, ffsa_pkg::t_stats s);
        bit [1:0] e_st;
        bit [15:0] e_ofs;
        ffsa_pkg::t_stats e;
        if (exp_status.size() == 0) begin
            $error("response with nothing expected");
            errors++;
            return;
        end
        e_st = exp_status.pop_front();
        e_ofs = exp_offset.pop_front();
        e = exp_stats.pop_front();
        if (st !== e_st) begin
            $error("status: expected %0d, got %0d", e_st, st); errors++;
        end
        if (ofs !== e_ofs) begin
            $error("alloc_offset: expected %0d, got %0d", e_ofs, ofs); errors++;
        end
        if (s.active_count !== e.active_count) begin
            $error("active_count: expected %0d, got %0d", e.active_count, s.active_count);
            errors++;
        end
        if (s.total_count !== e.total_count) begin
            $error("total_count: expected %0d, got %0d", e.total_count, s.total_count);
            errors++;
        end
        if (s.fail_count !== e.fail_count) begin
            $error("fail_count: expected %0d, got %0d", e.fail_count, s.fail_count);
            errors++;
        end
        if (s.active_bytes !== e.active_bytes) begin
            $error("active_bytes: expected %0d, got %0d", e.active_bytes, s.active_bytes);
            errors++;
        end
        if (s.total_bytes !== e.total_bytes) begin
            $error("total_bytes: expected %0d, got %0d", e.total_bytes, s.total_bytes);
            errors++;
        end
        if (s.fail_bytes !== e.fail_bytes) begin
            $error("fail_bytes: expected %0d, got %0d", e.fail_bytes, s.fail_bytes);
            errors++;
        end
        if (s.highest_byte !== e.highest_byte) begin
            $error("highest_byte: expected %0d, got %0d", e.highest_byte, s.highest_byte);
            errors++;
        end
    endfunction

    // pick the start of a random allocated segment, if any
    function bit pick_used(output bit [15:0] ofs);
        int unsigned n;
        int unsigned k;
        n = 0;
        ofs = 0;
        for (int unsigned i = 0; i < seg_cnt; i++) if (!seg_free[i]) n++;
        if (n == 0) return 0;
        k = $urandom_range(n - 1);
        for (int unsigned i = 0; i < seg_cnt; i++)
            if (!seg_free[i]) begin
                if (k == 0) begin
                    ofs = 16'(seg_start[i]);
                    return 1;
                end
                k--;
            end
        return 0;
    endfunction
endclass

module first_fit_segment_allocator_tb;

    localparam int N_RANDOM   = 1290;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    ffsa_in_if  req_if ();
    ffsa_out_if rsp_if ();

    first_fit_segment_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    heap_scoreboard sb;
    bit  src_idle_en;
    bit  sink_idle_en;
    bit  hold_sink;
    int  n_sent;
    int  n_recv;
    int  idle_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // response side: sample at rising edge, check accepted transactions
    always @(posedge i_clk) begin
        ffsa_pkg::t_stats s;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            s.active_count = rsp_if.active_count;
            s.total_count  = rsp_if.total_count;
            s.fail_count   = rsp_if.fail_count;
            s.active_bytes = rsp_if.active_bytes;
            s.total_bytes  = rsp_if.total_bytes;
            s.fail_bytes   = rsp_if.fail_bytes;
            s.highest_byte = rsp_if.highest_byte;
            sb.check_response(rsp_if.status, rsp_if.alloc_offset, s);
            n_recv++;
        end
    end

    // ready driver with random stall bursts
    initial begin
        int burst;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                rsp_if.ready = 1'b0;
            end else if (sink_idle_en && $urandom_range(9) == 0) begin
                burst = $urandom_range(1, 16);
                rsp_if.ready = 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    // valid stays high between back-to-back transactions; idling or drain drops it
    task automatic send(ffsa_pkg::t_cmd cmd, bit [31:0] sz, bit [31:0] cnt,
                        bit [15:0] ofs, bit is_null);
        if (src_idle_en && $urandom_range(7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.cmd          <= cmd;
        req_if.req_size     <= sz;
        req_if.elem_count   <= cnt;
        req_if.free_offset  <= ofs;
        req_if.null_pointer <= is_null;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(cmd, sz, cnt, ofs, is_null);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.exp_status.size() != 0) @(negedge i_clk);
    endtask

    // a random request biased toward small sizes and valid frees
    task automatic send_random();
        int unsigned pick;
        bit [15:0] ofs;
        bit [31:0] sz;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: sz = $urandom_range(1, 64);
            1: sz = $urandom_range(0, 2048);
            2: sz = $urandom_range(0, 70000);
            default: sz = $urandom;
        endcase
        if (pick < 45) begin
            send(ffsa_pkg::CMD_ALLOC, sz, $urandom, 16'($urandom), 1'($urandom));
        end else if (pick < 80) begin
            if (!sb.pick_used(ofs) || $urandom_range(9) == 0) ofs = 16'($urandom);
            send(ffsa_pkg::CMD_FREE, $urandom, $urandom, ofs, $urandom_range(19) == 0);
        end else if (pick < 95) begin
            if ($urandom_range(3) == 0)
                send(ffsa_pkg::CMD_ZALLOC, $urandom, $urandom, 16'($urandom),
                     1'($urandom));
            else
                send(ffsa_pkg::CMD_ZALLOC, $urandom_range(0, 64), $urandom_range(0, 64),
                     16'($urandom), 1'($urandom));
        end else begin
            send(ffsa_pkg::CMD_NONE, $urandom, $urandom, 16'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        n_sent = 0;
        n_recv = 0;
        hold_sink = 0;
        src_idle_en = 0;
        sink_idle_en = 0;
        req_if.valid = 1'b0;
        req_if.cmd = ffsa_pkg::CMD_NONE;
        req_if.req_size = '0;
        req_if.elem_count = '0;
        req_if.free_offset = '0;
        req_if.null_pointer = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero size, oversize, null and bad frees
        send(ffsa_pkg::CMD_ALLOC, 32'd0, 32'd0, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_ALLOC, 32'd100, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send(ffsa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_ALLOC, 32'd65537, 32'd0, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_ZALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_ZALLOC, 32'd0, 32'd5, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_ZALLOC, 32'd16, 32'd4, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_ZALLOC, 32'd256, 32'd257, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'd1, 1'b1);
        send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'd1, 1'b0);
        send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'd1, 1'b0);   // double free
        send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'hFFFF, 1'b0);
        send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'd0, 1'b0);    // merge with right
        send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'd101, 1'b0);
        send(ffsa_pkg::CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        // whole heap while a block is still allocated (no fit), then one byte, released
        send(ffsa_pkg::CMD_ALLOC, 32'd65536, 32'd0, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_ALLOC, 32'd1, 32'd0, 16'd0, 1'b0);
        send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'd0, 1'b0);
        // fill the table with one-byte blocks until it reports full
        for (int i = 0; i < 66; i++) send(ffsa_pkg::CMD_ALLOC, 32'd1, 32'd0, 16'd0, 1'b0);
        // free every other block, then the rest, to exercise both merges
        for (int i = 0; i < 64; i += 2)
            send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'(i), 1'b0);
        for (int i = 1; i < 64; i += 2)
            send(ffsa_pkg::CMD_FREE, 32'd0, 32'd0, 16'(i), 1'b0);
        drain();

        // random with idling on both sides
        src_idle_en = 1;
        sink_idle_en = 1;
        for (int i = 0; i < N_RANDOM * 2 / 3; i++) send_random();

        // long receiver hold-off while requests keep coming
        hold_sink = 1;
        fork
            repeat (400) @(posedge i_clk);
            for (int i = 0; i < 8; i++) send_random();
        join_any
        hold_sink = 0;
        wait fork;

        // sender pause until everything has come back
        drain();

        // tail: no idling
        src_idle_en = 0;
        sink_idle_en = 0;
        for (int i = 0; i < N_RANDOM / 3; i++) send_random();

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.exp_status.size() != 0) sb.errors++;
        $display("requests %0d, responses %0d: %0d grants, %0d frees, %0d no-fit,",
                 n_sent, n_recv, sb.allocs_ok, sb.frees_ok, sb.nofits);
        $display("%0d table-full, %0d invalid frees", sb.fulls, sb.badfrees);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
